>>> design/zci_pkg.sv
// ----------------------------------------------------------------------------
// zci_pkg - shared types and constants for the zero-crossing interpolator
// Sequencer states, crossing kind codes and default field widths.
// ----------------------------------------------------------------------------
package zci_pkg;

  localparam int unsigned DEF_X_WIDTH = 32;
  localparam int unsigned DEF_Y_WIDTH = 24;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_RISE = 2'd1;
  localparam logic [1:0] KIND_FALL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

>>> design/zero_crossing_interpolator_top.sv
// ----------------------------------------------------------------------------
// zero_crossing_interpolator_top - zero-crossing detector, linear interpolation
// Finds the zeros of a sampled function and reports their abscissae.
// ----------------------------------------------------------------------------
// Samples (x, y) arrive one word at a time in rising x order; tuser set marks
// the first sample of a new function. A sample with y exactly zero gives its
// own x (kind 0). Otherwise a strict sign change against the previous sample
// gives x0 - y0*(x1-x0)/(y1-y0), truncated toward zero in raw x units, kind 1
// for a rising and kind 2 for a falling crossing. x is signed two's complement
// (Q16.16 at the default 32 bits), y a signed integer. Each accepted word is
// examined in a prepare state: with nothing found the block goes back to idle,
// an exact zero goes on to the finish state, and an interpolated crossing
// first passes through a shared mul-div unit that walks the X_WIDTH+1 bits
// of |x1-x0| one per cycle, doing two compare-and-subtract steps against
// |y1-y0| each cycle. The result sits in an output register, so a new word is
// taken while a result waits downstream; the block holds off new words while it
// is busy with one, also while a finished result waits for the output register.
// ----------------------------------------------------------------------------
module zero_crossing_interpolator_top
  import zci_pkg::*;
#(
  parameter int unsigned X_WIDTH = DEF_X_WIDTH,
  parameter int unsigned Y_WIDTH = DEF_Y_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input sample stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata: sample_x [X_WIDTH-1:0], sample_y [X_WIDTH+Y_WIDTH-1:X_WIDTH], zero pad
  input  logic [((X_WIDTH+Y_WIDTH+7)/8)*8-1:0]   s_tdata,
  // s_tuser: first_sample [0]
  input  logic                                   s_tuser,
  // crossing result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata: crossing_x [X_WIDTH-1:0], zero pad
  output logic [((X_WIDTH+7)/8)*8-1:0]           m_tdata,
  // m_tuser: crossing_kind [1:0]
  output logic [1:0]                             m_tuser
);

  localparam int unsigned OUT_TDATA_W = ((X_WIDTH + 7) / 8) * 8;
  localparam int unsigned CNT_W       = $clog2(X_WIDTH + 1);
  localparam int unsigned REM_W       = Y_WIDTH + 2;

  state_t state, state_next;

  // captured sample and the one before it
  logic signed [X_WIDTH-1:0] cur_x;
  logic signed [Y_WIDTH-1:0] cur_y;
  logic                      cur_first;
  logic signed [X_WIDTH-1:0] prev_x;
  logic signed [Y_WIDTH-1:0] prev_y;
  logic                      have_prev;

  // mul-div operands and working registers
  logic [X_WIDTH:0]          mag_dx;   // shifted left, MSB consumed each step
  logic [Y_WIDTH-1:0]        mag_y0;
  logic [Y_WIDTH:0]          mag_dy;
  logic [REM_W-1:0]          rem;
  logic [X_WIDTH:0]          quo;
  logic [CNT_W-1:0]          cnt;
  logic                      neg;
  logic [X_WIDTH-1:0]        base_x;
  logic [1:0]                kind;

  // output register
  logic [X_WIDTH-1:0]        out_x;
  logic [1:0]                out_kind;

  logic accept;
  logic load;

  // decision on the captured word
  logic                      use_prev;
  logic                      is_zero;
  logic                      is_cross;
  logic signed [X_WIDTH:0]   dx;
  logic signed [Y_WIDTH:0]   dy;

  // one step of the shared unit
  logic [REM_W-1:0]          t1, r1, t2, r2;
  logic [REM_W-1:0]          d_ext;
  logic                      c1, c2;
  logic [X_WIDTH:0]          res_wide;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign load     = (state == ST_FIN) && (!m_tvalid || m_tready);

  assign m_tdata  = OUT_TDATA_W'(out_x);
  assign m_tuser  = out_kind;

  always_comb begin
    use_prev = have_prev && !cur_first;
    is_zero  = (cur_y == '0);
    is_cross = use_prev &&
               (((prev_y < 0) && (cur_y > 0)) || ((prev_y > 0) && (cur_y < 0)));
    dx = {cur_x[X_WIDTH-1], cur_x} - {prev_x[X_WIDTH-1], prev_x};
    dy = {cur_y[Y_WIDTH-1], cur_y} - {prev_y[Y_WIDTH-1], prev_y};
  end

  // two restoring steps: double the remainder and reduce it by dy, then add y0 if the dx bit is set and reduce again
  always_comb begin
    d_ext = REM_W'(mag_dy);
    t1    = {rem[REM_W-2:0], 1'b0};
    c1    = (t1 >= d_ext);
    r1    = c1 ? (t1 - d_ext) : t1;
    t2    = r1 + (mag_dx[X_WIDTH] ? REM_W'(mag_y0) : '0);
    c2    = (t2 >= d_ext);
    r2    = c2 ? (t2 - d_ext) : t2;
    res_wide = neg ? ({1'b0, base_x} + quo) : ({1'b0, base_x} - quo);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (is_zero)       state_next = ST_FIN;
        else if (is_cross) state_next = ST_DIV;
        else               state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(X_WIDTH)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // stored sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (state == ST_PREP) begin
      prev_x    <= cur_x;
      prev_y    <= cur_y;
      have_prev <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x     <= s_tdata[X_WIDTH-1:0];
      cur_y     <= s_tdata[X_WIDTH+Y_WIDTH-1:X_WIDTH];
      cur_first <= s_tuser;
    end
    if (state == ST_PREP) begin
      rem <= '0;
      quo <= '0;
      cnt <= '0;
      if (is_zero) begin
        base_x <= cur_x;
        neg    <= 1'b0;
        kind   <= KIND_ZERO;
      end else begin
        base_x <= prev_x;
        mag_dx <= dx[X_WIDTH] ? (X_WIDTH+1)'(-dx) : (X_WIDTH+1)'(dx);
        mag_y0 <= prev_y[Y_WIDTH-1] ? Y_WIDTH'(-prev_y) : Y_WIDTH'(prev_y);
        mag_dy <= dy[Y_WIDTH] ? (Y_WIDTH+1)'(-dy) : (Y_WIDTH+1)'(dy);
        neg    <= (dx[X_WIDTH] ^ prev_y[Y_WIDTH-1]) ^ dy[Y_WIDTH];
        kind   <= prev_y[Y_WIDTH-1] ? KIND_RISE : KIND_FALL;
      end
    end
    if (state == ST_DIV) begin
      rem    <= r2;
      quo    <= {quo[X_WIDTH-1:0], 1'b0} + (X_WIDTH+1)'(c1) + (X_WIDTH+1)'(c2);
      mag_dx <= {mag_dx[X_WIDTH-1:0], 1'b0};
      cnt    <= cnt + 1'b1;
    end
    if (load) begin
      out_x    <= res_wide[X_WIDTH-1:0];
      out_kind <= kind;
    end
  end

  // result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for zero_crossing_interpolator_top
// Sample words go in through a bursty sender, and crossing words are drained
// by a receiver that stalls on its own schedule. Every crossing word is
// checked against a behavioural predictor of the interpolator.
// ----------------------------------------------------------------------------
module testbench;
  import zci_pkg::*;

  localparam int unsigned X_W          = DEF_X_WIDTH;
  localparam int unsigned Y_W          = DEF_Y_WIDTH;
  localparam int unsigned S_TDATA_W    = ((X_W + Y_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W    = ((X_W + 7) / 8) * 8;
  localparam int unsigned SAMPLE_COUNT = 1350;
  // extra wait at the end, beyond the slowest word's time through the block
  localparam int unsigned DRAIN_CYCLES = X_W + 12;
  // cycles with no accepted word on either side before giving up
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [1:0]     kind;
  } crossing_t;

  // receiver behaviour, picked anew at random when the current mode runs out
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready when the 3-bit phase counter is zero
    RX_CHOKE    // ready when a random draw from 0 to 15 is zero
  } rx_mode_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;

  // predictor state: last sample seen and whether there is one
  logic [X_W-1:0] last_x      = '0;
  logic [Y_W-1:0] last_y      = '0;
  logic           have_last   = 1'b0;

  crossing_t      pending_crossings[$];
  int unsigned    mismatch_count = 0;
  int unsigned    samples_sent   = 0;
  int unsigned    burst_left     = 0;
  int unsigned    quiet_cycles   = 0;

  rx_mode_t       rx_mode        = RX_OPEN;
  int unsigned    rx_mode_left   = 0;
  logic [2:0]     rx_phase       = '0;

  zero_crossing_interpolator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: exact zero gives its own x; a strict sign change against the
  // stored sample gives x0 - y0*(x1-x0)/(y1-y0), truncated toward zero. The
  // product stays below 2^57, so 64-bit signed arithmetic is exact, and SV
  // signed division already truncates toward zero.
  // --------------------------------------------------------------------------
  task automatic predict_crossing(input logic first, input logic [X_W-1:0] x,
                                  input logic [Y_W-1:0] y);
    longint    x0, x1, y0, y1, dx, dy, xr;
    crossing_t c;
    x0 = $signed(last_x);
    y0 = $signed(last_y);
    x1 = $signed(x);
    y1 = $signed(y);
    if (y1 == 0) begin
      c.x    = x;
      c.kind = KIND_ZERO;
      pending_crossings.push_back(c);
    end else if (have_last && !first && ((y0 < 0 && y1 > 0) || (y0 > 0 && y1 < 0))) begin
      dx     = x1 - x0;
      dy     = y1 - y0;
      xr     = x0 - (dx * y0) / dy;
      c.x    = xr[X_W-1:0];
      c.kind = (y0 < 0) ? KIND_RISE : KIND_FALL;
      pending_crossings.push_back(c);
    end
    last_x    = x;
    last_y    = y;
    have_last = 1'b1;
  endtask

  function automatic void note_mismatch(input string what);
    if (mismatch_count < REPORT_MAX)
      $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one sample word. Called and returning at a rising edge. Words go
  // out in bursts of random length; a random gap, sometimes none, precedes each burst. Ready
  // is looked at on the falling edge, so the accept edge is known race-free.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic first, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y);
    int unsigned          gap;
    logic [S_TDATA_W-1:0] word;
    logic                 taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    word                 = '0;
    word[X_W-1:0]        = x;
    word[X_W+Y_W-1:X_W]  = y;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= first;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    predict_crossing(first, x, y);
    samples_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_phase <= rx_phase + 3'd1;
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(50, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_phase == 3'd0);
      default:   m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result check: a word seen valid and ready here is taken at the next edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_check
    crossing_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_crossings.size() == 0) begin
        note_mismatch($sformatf("unexpected word x=%h kind=%0d",
                                m_tdata[X_W-1:0], m_tuser));
      end else begin
        want = pending_crossings.pop_front();
        if (m_tdata[X_W-1:0] !== want.x)
          note_mismatch($sformatf("crossing_x expected %h got %h (kind %0d)",
                                  want.x, m_tdata[X_W-1:0], want.kind));
        if (m_tuser !== want.kind)
          note_mismatch($sformatf("crossing_kind expected %0d got %0d (x %h)",
                                  want.kind, m_tuser, want.x));
      end
    end
  end

  // watchdog: no progress on either side for too long ends the run
  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // nothing stored after reset: the first word finds nothing even without the first flag, and the second pairs with it
  task automatic test_reset_state();
    send_sample(1'b0, 32'sd100, -24'sd5);
    send_sample(1'b0, 32'sd200, 24'sd5);
  endtask

  // exact zero at the start of a function, then a zero neighbour
  task automatic test_exact_zero();
    send_sample(1'b1, 32'h8000_0000, 24'd0);
    send_sample(1'b0, 32'h7fff_ffff, 24'd0);
    send_sample(1'b1, 32'h0001_0000, 24'd0);
    send_sample(1'b0, 32'h0002_0000, 24'sd7);   // previous zero: no crossing
    send_sample(1'b0, 32'h0003_0000, -24'sd3);  // falling
  endtask

  // widest span in x and y, both directions
  task automatic test_extreme_crossings();
    send_sample(1'b1, 32'h8000_0000, 24'h80_0000);
    send_sample(1'b0, 32'h7fff_ffff, 24'h7f_ffff);
    send_sample(1'b1, 32'h8000_0000, 24'h7f_ffff);
    send_sample(1'b0, 32'h7fff_ffff, 24'h80_0000);
    send_sample(1'b1, 32'h8000_0000, -24'sd1);
    send_sample(1'b0, 32'h7fff_ffff, 24'sd1);
  endtask

  // small steps where the quotient is truncated toward zero
  task automatic test_edge_direction();
    send_sample(1'b1, 32'sd0, 24'sd3);
    send_sample(1'b0, 32'sd10, -24'sd4);
    send_sample(1'b0, 32'sd11, 24'sd1);
  endtask

  // a new function must not pair with the last sample of the old one
  task automatic test_first_flag();
    send_sample(1'b1, 32'sd0, -24'sd5);
    send_sample(1'b1, 32'sd5, 24'sd5);
  endtask

  // x going backwards, then equal x
  task automatic test_odd_x();
    send_sample(1'b1, 32'sd1000, -24'sd7);
    send_sample(1'b0, -32'sd500, 24'sd9);
    send_sample(1'b0, -32'sd500, -24'sd1);
  endtask

  // --------------------------------------------------------------------------
  // Random functions: mostly well-formed runs with a mix of step sizes and
  // value profiles, some broken runs (backward steps, stray first flags) and
  // some pure noise.
  // --------------------------------------------------------------------------
  task automatic test_random_functions(input int unsigned target);
    int unsigned    shape, len, x_mode, y_mode, step, mag, i;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           first;
    while (samples_sent < target) begin
      shape  = $urandom_range(0, 9);
      len    = $urandom_range(2, 24);
      x_mode = $urandom_range(0, 2);
      y_mode = $urandom_range(0, 3);
      x      = X_W'($urandom);
      y      = '0;
      for (i = 0; i < len; i++) begin
        first = (i == 0);
        if (shape == 0) begin
          first = 1'($urandom_range(0, 1));
          x     = X_W'($urandom);
          y     = Y_W'($urandom);
        end else begin
          if (i != 0) begin
            case (x_mode)
              0:       step = $urandom_range(1, 16);
              1:       step = $urandom_range(1, 262144);
              default: step = $urandom >> $urandom_range(0, 31);  // zero now and then
            endcase
            if (shape == 1 && $urandom_range(0, 3) == 0)
              x = X_W'(x - step);
            else
              x = X_W'(x + step);
            if (shape == 1 && $urandom_range(0, 7) == 0)
              first = 1'b1;
          end
          case (y_mode)
            0:       y = Y_W'($urandom_range(0, 8) - 4);
            1:       y = Y_W'($urandom_range(0, 2000) - 1000);
            2:       y = Y_W'($urandom);
            default: begin
              // alternating sign, large magnitudes, extremes now and then
              mag = $urandom_range(1, 8388607);
              if ($urandom_range(0, 7) == 0)
                y = i[0] ? 24'h80_0000 : 24'h7f_ffff;
              else
                y = i[0] ? Y_W'(-mag) : Y_W'(mag);
            end
          endcase
        end
        send_sample(first, x, y);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_exact_zero();
    test_extreme_crossings();
    test_edge_direction();
    test_first_flag();
    test_odd_x();
    test_random_functions(SAMPLE_COUNT);

    s_tvalid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_crossings.size() != 0)
      note_mismatch($sformatf("%0d crossing words never arrived",
                              pending_crossings.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
